[hdl/qte_pkg.sv]
// Package for the quaternion to Euler bin converter.
// Holds the shared widths, angle constants and the arctangent table.
// No dependencies.
package qte_pkg;

  localparam int NUM_BINS  = 18;
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int BIN_W     = 5;

  // Widths of the atan2 datapath.
  localparam int ARG_W = 35;  // signed atan2 operands
  localparam int MAG_W = 33;  // operand magnitudes
  localparam int NRM_W = 30;  // normalized magnitudes, top bit at 2^29
  localparam int CX_W  = 34;  // CORDIC x and y
  localparam int ANG_W = 34;  // binary angle, 2^32 per turn

  localparam int CORDIC_STEPS = 31;
  localparam int AT_LAT       = 3 + CORDIC_STEPS;

  localparam int ISQ_STEPS = 30;
  localparam int ISQ_W     = 60;
  localparam int ISQ_LAT   = ISQ_STEPS;

  // The pitch magnitude is scaled by this left shift to reach the normalized range.
  localparam int PITCH_SH = (NRM_W - 1) - 2 * FRAC_BITS;

  localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(64'd1 << 31);
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(64'd1 << 30);

  function automatic logic signed [ANG_W-1:0] atan_ang(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = ANG_W'(536870912);
      1:  v = ANG_W'(316933406);
      2:  v = ANG_W'(167458907);
      3:  v = ANG_W'(85004756);
      4:  v = ANG_W'(42667331);
      5:  v = ANG_W'(21354465);
      6:  v = ANG_W'(10679838);
      7:  v = ANG_W'(5340245);
      8:  v = ANG_W'(2670163);
      9:  v = ANG_W'(1335087);
      10: v = ANG_W'(667544);
      11: v = ANG_W'(333772);
      12: v = ANG_W'(166886);
      13: v = ANG_W'(83443);
      14: v = ANG_W'(41722);
      15: v = ANG_W'(20861);
      16: v = ANG_W'(10430);
      17: v = ANG_W'(5215);
      18: v = ANG_W'(2608);
      19: v = ANG_W'(1304);
      20: v = ANG_W'(652);
      21: v = ANG_W'(326);
      22: v = ANG_W'(163);
      23: v = ANG_W'(81);
      24: v = ANG_W'(41);
      25: v = ANG_W'(20);
      26: v = ANG_W'(10);
      27: v = ANG_W'(5);
      28: v = ANG_W'(3);
      29: v = ANG_W'(1);
      30: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/qte_quat_if.sv]
// Input channel of the quaternion to Euler bin converter.
// Carries one quaternion per transaction; depends on qte_pkg.
interface qte_quat_if import qte_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] quat_w;
  logic signed [IN_W-1:0] quat_x;
  logic signed [IN_W-1:0] quat_y;
  logic signed [IN_W-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

[hdl/qte_bins_if.sv]
// Output channel of the quaternion to Euler bin converter.
// Carries the three angle bins per transaction; depends on qte_pkg.
interface qte_bins_if import qte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] roll_bin;
  logic [BIN_W-1:0] pitch_bin;
  logic [BIN_W-1:0] yaw_bin;

  modport source (output valid, output roll_bin, output pitch_bin, output yaw_bin,
                  input ready);
  modport sink (input valid, input roll_bin, input pitch_bin, input yaw_bin,
                output ready);
endinterface

[hdl/qte_isqrt.sv]
// Pipelined integer floor square root, one result bit per stage.
// Depends on qte_pkg.
module qte_isqrt import qte_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ISQ_W-1:0] rad_i,
  output logic [NRM_W-1:0] root_o
);

  logic [ISQ_W-1:0] v_q [ISQ_STEPS];
  logic [ISQ_W-1:0] r_q [ISQ_STEPS];

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_step
    localparam logic [ISQ_W-1:0] BitV = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
    logic [ISQ_W-1:0] v_in, r_in, t;

    if (j == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = v_q[j-1];
      assign r_in = r_q[j-1];
    end

    assign t = r_in + BitV;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= t) begin
          v_q[j] <= v_in - t;
          r_q[j] <= (r_in >> 1) + BitV;
        end else begin
          v_q[j] <= v_in;
          r_q[j] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[ISQ_STEPS-1][NRM_W-1:0];

endmodule

[hdl/qte_atan2.sv]
// Pipelined atan2 in binary angle units: magnitude normalization over three
// stages, then one CORDIC vectoring step per stage. Depends on qte_pkg.
module qte_atan2 import qte_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ARG_W-1:0] a_i,
  input  logic signed [ARG_W-1:0] b_i,
  output logic signed [ANG_W-1:0] z_o
);

  // Stage 1: magnitudes and the axis cases.
  logic [MAG_W-1:0] ua_q, ub_q;
  logic             aneg_q, bneg_q, azero_q, bzero_q;
  logic [ARG_W-1:0] ua_full, ub_full;

  assign ua_full = a_i[ARG_W-1] ? ARG_W'(-a_i) : ARG_W'(a_i);
  assign ub_full = b_i[ARG_W-1] ? ARG_W'(-b_i) : ARG_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q    <= ua_full[MAG_W-1:0];
      ub_q    <= ub_full[MAG_W-1:0];
      aneg_q  <= a_i[ARG_W-1];
      bneg_q  <= b_i[ARG_W-1];
      azero_q <= (a_i == '0);
      bzero_q <= (b_i == '0);
    end
  end

  // Stage 2: left-justify by 16, 8 and 4.
  logic [MAG_W-1:0] p2_q, q2_q;
  logic             aneg2_q, bneg2_q, azero2_q, bzero2_q;
  logic [MAG_W-1:0] p2_d, q2_d, m2;

  always_comb begin
    p2_d = ua_q;
    q2_d = ub_q;
    m2   = ua_q | ub_q;
    if (m2[MAG_W-1 -: 16] == '0) begin
      p2_d = p2_d << 16; q2_d = q2_d << 16; m2 = m2 << 16;
    end
    if (m2[MAG_W-1 -: 8] == '0) begin
      p2_d = p2_d << 8; q2_d = q2_d << 8; m2 = m2 << 8;
    end
    if (m2[MAG_W-1 -: 4] == '0) begin
      p2_d = p2_d << 4; q2_d = q2_d << 4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q     <= p2_d;
      q2_q     <= q2_d;
      aneg2_q  <= aneg_q;
      bneg2_q  <= bneg_q;
      azero2_q <= azero_q;
      bzero2_q <= bzero_q;
    end
  end

  // Stage 3: last shifts, signs back, turn into the right half plane.
  // Left-justifying and dropping the three low bits equals the scaling to [2^29, 2^30).
  logic signed [CX_W-1:0]  x0_q, y0_q;
  logic signed [ANG_W-1:0] z0_q, spcz0_q;
  logic                    spc0_q;
  logic [MAG_W-1:0]        p3, q3, m3;
  logic signed [CX_W-1:0]  xs, ys, x3_d, y3_d;
  logic signed [ANG_W-1:0] z3_d, spcz3_d;

  always_comb begin
    p3 = p2_q;
    q3 = q2_q;
    m3 = p2_q | q2_q;
    if (m3[MAG_W-1 -: 2] == '0) begin
      p3 = p3 << 2; q3 = q3 << 2; m3 = m3 << 2;
    end
    if (m3[MAG_W-1] == 1'b0) begin
      p3 = p3 << 1; q3 = q3 << 1;
    end
    ys = signed'(CX_W'(p3[MAG_W-1 -: NRM_W]));
    xs = signed'(CX_W'(q3[MAG_W-1 -: NRM_W]));
    if (aneg2_q) ys = -ys;
    if (bneg2_q) xs = -xs;
    x3_d = xs;
    y3_d = ys;
    z3_d = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x3_d = ys; y3_d = -xs; z3_d = ANG_QUARTER;
      end else begin
        x3_d = -ys; y3_d = xs; z3_d = -ANG_QUARTER;
      end
    end
    if (azero2_q) begin
      spcz3_d = bneg2_q ? ANG_HALF : '0;
    end else begin
      spcz3_d = aneg2_q ? -ANG_QUARTER : ANG_QUARTER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= x3_d;
      y0_q    <= y3_d;
      z0_q    <= z3_d;
      spc0_q  <= azero2_q | bzero2_q;
      spcz0_q <= spcz3_d;
    end
  end

  // CORDIC vectoring steps.
  logic signed [CX_W-1:0]  x_q [CORDIC_STEPS];
  logic signed [CX_W-1:0]  y_q [CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_q [CORDIC_STEPS];
  logic signed [ANG_W-1:0] spcz_q [CORDIC_STEPS];
  logic                    spc_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0]  x_in, y_in;
    logic signed [ANG_W-1:0] z_in, spcz_in;
    logic                    spc_in;

    if (i == 0) begin : g_first
      assign x_in    = x0_q;
      assign y_in    = y0_q;
      assign z_in    = z0_q;
      assign spc_in  = spc0_q;
      assign spcz_in = spcz0_q;
    end else begin : g_rest
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign spc_in  = spc_q[i-1];
      assign spcz_in = spcz_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_in >= 0) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + atan_ang(i);
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - atan_ang(i);
        end
        spc_q[i]  <= spc_in;
        spcz_q[i] <= spcz_in;
      end
    end
  end

  assign z_o = spc_q[CORDIC_STEPS-1] ? spcz_q[CORDIC_STEPS-1] : z_q[CORDIC_STEPS-1];

endmodule

[hdl/quaternion_to_euler_bins.sv]
// Quaternion to quantized roll, pitch and yaw bins; depends on qte_pkg and the channel interfaces.
// Pipeline: 70 register stages (products, sums, square, radicand, 30 square-root, 34 atan2,
// bin scaling, out). Throughput: one transaction per cycle while the skid register is empty;
// every stage advances together and a skid register after the output register takes one more
// result while the output waits.
// Reset clears the valid bits, those of the output and skid registers too; data is not reset.
module quaternion_to_euler_bins import qte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  qte_quat_if.sink   quat_i,
  qte_bins_if.source bins_o
);

  localparam int PIPE_LEN = 4 + ISQ_LAT + AT_LAT + 1;
  localparam int RY_DLY   = 2 + ISQ_LAT;
  localparam int PRD_W    = ANG_W + 6;

  localparam logic signed [ARG_W-1:0] ONE_A  = ARG_W'(1) << (2 * FRAC_BITS);
  localparam logic [ISQ_W-1:0]        ONE_N2 = ISQ_W'(1) << (2 * (NRM_W - 1));

  logic                en;
  logic [PIPE_LEN-1:0] vld_q;
  logic                out_v_q, skid_v_q;

  assign en           = !skid_v_q;
  assign quat_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], quat_i.valid};
    end
  end

  // Stage 1: products.
  logic signed [2*IN_W-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q, p_wy_q, p_zx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= quat_i.quat_w * quat_i.quat_x;
      p_yz_q <= quat_i.quat_y * quat_i.quat_z;
      p_xx_q <= quat_i.quat_x * quat_i.quat_x;
      p_yy_q <= quat_i.quat_y * quat_i.quat_y;
      p_wz_q <= quat_i.quat_w * quat_i.quat_z;
      p_xy_q <= quat_i.quat_x * quat_i.quat_y;
      p_zz_q <= quat_i.quat_z * quat_i.quat_z;
      p_wy_q <= quat_i.quat_w * quat_i.quat_y;
      p_zx_q <= quat_i.quat_z * quat_i.quat_x;
    end
  end

  // Stage 2: atan2 operands and the clamped pitch sine.
  logic signed [ARG_W-1:0] ra_q, rb_q, ya_q, yb_q;
  logic signed [ARG_W-1:0] s_raw, s_cl;
  logic [ARG_W-1:0]        s_mag;
  logic [NRM_W-1:0]        usn_d, usn2_q, usn3_q, usn4_q;
  logic                    sgn2_q, sgn3_q, sgn4_q;

  always_comb begin
    s_raw = (ARG_W'(p_wy_q) - ARG_W'(p_zx_q)) <<< 1;
    s_cl  = s_raw;
    if (s_raw > ONE_A) s_cl = ONE_A;
    if (s_raw < -ONE_A) s_cl = -ONE_A;
    s_mag = s_cl[ARG_W-1] ? ARG_W'(-s_cl) : ARG_W'(s_cl);
    usn_d = s_mag[NRM_W-1:0] << PITCH_SH;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q   <= (ARG_W'(p_wx_q) + ARG_W'(p_yz_q)) <<< 1;
      rb_q   <= ONE_A - ((ARG_W'(p_xx_q) + ARG_W'(p_yy_q)) <<< 1);
      ya_q   <= (ARG_W'(p_wz_q) + ARG_W'(p_xy_q)) <<< 1;
      yb_q   <= ONE_A - ((ARG_W'(p_yy_q) + ARG_W'(p_zz_q)) <<< 1);
      usn2_q <= usn_d;
      sgn2_q <= s_cl[ARG_W-1];
    end
  end

  // Stages 3 and 4: radicand of the pitch cosine.
  logic [ISQ_W-1:0] sq_q, rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q   <= ISQ_W'(usn2_q) * ISQ_W'(usn2_q);
      usn3_q <= usn2_q;
      sgn3_q <= sgn2_q;
      rad_q  <= ONE_N2 - sq_q;
      usn4_q <= usn3_q;
      sgn4_q <= sgn3_q;
    end
  end

  logic [NRM_W-1:0] cos_root;

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (cos_root)
  );

  // The pitch sine waits alongside the square root.
  logic [NRM_W:0] sn_dly_q [ISQ_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_dly_q[0] <= {sgn4_q, usn4_q};
      for (int k = 1; k < ISQ_LAT; k++) begin
        sn_dly_q[k] <= sn_dly_q[k-1];
      end
    end
  end

  logic signed [ARG_W-1:0] pa, pb;

  assign pa = sn_dly_q[ISQ_LAT-1][NRM_W] ? -signed'(ARG_W'(sn_dly_q[ISQ_LAT-1][NRM_W-1:0]))
                                         : signed'(ARG_W'(sn_dly_q[ISQ_LAT-1][NRM_W-1:0]));
  assign pb = signed'(ARG_W'(cos_root));

  logic signed [ANG_W-1:0] roll_z, yaw_z, pitch_z;

  qte_atan2 u_roll  (.clk_i(clk_i), .en_i(en), .a_i(ra_q), .b_i(rb_q), .z_o(roll_z));
  qte_atan2 u_yaw   (.clk_i(clk_i), .en_i(en), .a_i(ya_q), .b_i(yb_q), .z_o(yaw_z));
  qte_atan2 u_pitch (.clk_i(clk_i), .en_i(en), .a_i(pa), .b_i(pb), .z_o(pitch_z));

  // Roll and yaw wait for the pitch path.
  logic signed [ANG_W-1:0] roll_dly_q [RY_DLY];
  logic signed [ANG_W-1:0] yaw_dly_q [RY_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_dly_q[0] <= roll_z;
      yaw_dly_q[0]  <= yaw_z;
      for (int k = 1; k < RY_DLY; k++) begin
        roll_dly_q[k] <= roll_dly_q[k-1];
        yaw_dly_q[k]  <= yaw_dly_q[k-1];
      end
    end
  end

  function automatic logic [PRD_W-1:0] scale_ang(input logic signed [ANG_W-1:0] z,
                                                 input logic signed [ANG_W-1:0] off);
    logic signed [ANG_W-1:0] zc;
    logic [ANG_W-1:0]        u;
    zc = z;
    if (zc < -off) zc = -off;
    if (zc > off) zc = off;
    u = ANG_W'(zc + off);
    return PRD_W'(u) * PRD_W'(NUM_BINS);
  endfunction

  function automatic logic [BIN_W-1:0] to_bin(input logic [PRD_W-1:0] prd, input int sh);
    logic [PRD_W-1:0] r;
    r = prd >> sh;
    if (r > PRD_W'(NUM_BINS)) r = PRD_W'(NUM_BINS);
    return r[BIN_W-1:0];
  endfunction

  // Last pipeline stage: clamp, offset and scale by the bin count.
  logic [PRD_W-1:0] roll_prd_q, pitch_prd_q, yaw_prd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_prd_q  <= scale_ang(roll_dly_q[RY_DLY-1], ANG_HALF);
      yaw_prd_q   <= scale_ang(yaw_dly_q[RY_DLY-1], ANG_HALF);
      pitch_prd_q <= scale_ang(pitch_z, ANG_QUARTER);
    end
  end

  logic             up_v;
  logic [BIN_W-1:0] up_roll, up_pitch, up_yaw;

  assign up_v     = vld_q[PIPE_LEN-1];
  assign up_roll  = to_bin(roll_prd_q, 32);
  assign up_pitch = to_bin(pitch_prd_q, 31);
  assign up_yaw   = to_bin(yaw_prd_q, 32);

  // Output register with a skid register behind it.
  logic [BIN_W-1:0] out_roll_q, out_pitch_q, out_yaw_q;
  logic [BIN_W-1:0] skid_roll_q, skid_pitch_q, skid_yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (bins_o.ready || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= up_v;
      end
    end else if (up_v && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bins_o.ready || !out_v_q) begin
      if (skid_v_q) begin
        out_roll_q  <= skid_roll_q;
        out_pitch_q <= skid_pitch_q;
        out_yaw_q   <= skid_yaw_q;
      end else begin
        out_roll_q  <= up_roll;
        out_pitch_q <= up_pitch;
        out_yaw_q   <= up_yaw;
      end
    end else if (up_v && !skid_v_q) begin
      skid_roll_q  <= up_roll;
      skid_pitch_q <= up_pitch;
      skid_yaw_q   <= up_yaw;
    end
  end

  assign bins_o.valid     = out_v_q;
  assign bins_o.roll_bin  = out_roll_q;
  assign bins_o.pitch_bin = out_pitch_q;
  assign bins_o.yaw_bin   = out_yaw_q;

  // The skid register only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q) && !$past(bins_o.ready))
    else $error("skid register filled without an output stall");

  a_bins_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_roll_q <= BIN_W'(NUM_BINS)) && (out_pitch_q <= BIN_W'(NUM_BINS))
                && (out_yaw_q <= BIN_W'(NUM_BINS)))
    else $error("angle bin above the saturation limit");

endmodule

[bench/qte_bins_checker.sv]
// Watches both channels of the quaternion to Euler bin converter, predicts the bins
// of every accepted quaternion and compares them in order. Depends on qte_pkg and
// the two channel interfaces.
module qte_bins_checker import qte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  qte_quat_if  quat_i,
  qte_bins_if  bins_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BIN_W-1:0] roll;
    logic [BIN_W-1:0] pitch;
    logic [BIN_W-1:0] yaw;
  } bins_t;

  localparam longint TURN_HALF    = 64'sd1 <<< 31;
  localparam longint TURN_QUARTER = 64'sd1 <<< 30;
  localparam longint unsigned SPAN_HI = 64'd1 << 30;
  localparam longint unsigned SPAN_LO = 64'd1 << 29;

  bins_t expected_bins[$];
  int    fail_count = 0;

  assign fail_count_o = fail_count;

  initial pending_o = 0;

  function automatic longint unsigned abs_of(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Scales both magnitudes by one power of two so the larger lands in [2^29, 2^30).
  function automatic void scale_pair(inout longint unsigned p, inout longint unsigned q);
    longint unsigned m;
    m = p > q ? p : q;
    if (m == 0) return;
    while (m >= SPAN_HI) begin
      m = m >> 1; p = p >> 1; q = q >> 1;
    end
    while (m < SPAN_LO) begin
      m = m << 1; p = p << 1; q = q << 1;
    end
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint a, longint b);
    longint unsigned ua, ub;
    longint x, y, z, t, nx, ny;
    if (a == 0) return b < 0 ? TURN_HALF : 0;
    if (b == 0) return a > 0 ? TURN_QUARTER : -TURN_QUARTER;
    ua = abs_of(a);
    ub = abs_of(b);
    scale_pair(ua, ub);
    y = a < 0 ? -longint'(ua) : longint'(ua);
    x = b < 0 ? -longint'(ub) : longint'(ub);
    z = 0;
    // Fold the left half plane into the right one first.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = TURN_QUARTER;
      end else begin
        x = -y; y = t; z = -TURN_QUARTER;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(atan_ang(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(atan_ang(i));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic logic [BIN_W-1:0] angle_bin(longint z, longint off, int sh);
    longint unsigned r;
    if (z < -off) z = -off;
    if (z > off) z = off;
    r = (longint'(z + off) * NUM_BINS) >> sh;
    if (r > NUM_BINS) r = NUM_BINS;
    return BIN_W'(r);
  endfunction

  function automatic bins_t predict_bins(longint w, longint x, longint y, longint z);
    longint one, s, sn;
    longint unsigned us, uo, c;
    bins_t b;
    one = 64'sd1 <<< (2 * FRAC_BITS);
    s = 2 * (w * y - z * x);
    if (s > one) s = one;
    if (s < -one) s = -one;
    us = abs_of(s);
    uo = one;
    scale_pair(us, uo);
    c  = floor_sqrt(uo * uo - us * us);
    sn = s < 0 ? -longint'(us) : longint'(us);
    b.roll  = angle_bin(vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)),
                        TURN_HALF, 32);
    b.pitch = angle_bin(vector_angle(sn, longint'(c)), TURN_QUARTER, 31);
    b.yaw   = angle_bin(vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)),
                        TURN_HALF, 32);
    return b;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bins_t b;
    if (rst_ni) begin
      if (quat_i.valid && quat_i.ready)
        expected_bins = {expected_bins,
                         predict_bins(longint'(quat_i.quat_w), longint'(quat_i.quat_x),
                                      longint'(quat_i.quat_y), longint'(quat_i.quat_z))};
      if (bins_i.valid && bins_i.ready) begin
        if (expected_bins.size() == 0) begin
          report("unexpected transaction", 1, 0);
        end else begin
          b = expected_bins.pop_front();
          if (bins_i.roll_bin !== b.roll) report("roll_bin", bins_i.roll_bin, b.roll);
          if (bins_i.pitch_bin !== b.pitch) report("pitch_bin", bins_i.pitch_bin, b.pitch);
          if (bins_i.yaw_bin !== b.yaw) report("yaw_bin", bins_i.yaw_bin, b.yaw);
        end
      end
      pending_o <= expected_bins.size();
    end
  end

endmodule

[bench/quaternion_to_euler_bins_test.sv]
// Top of the quaternion to Euler bin converter testbench: clock, reset, stimulus and verdict.
// Depends on qte_pkg, both channel interfaces, the converter and qte_bins_checker.
module quaternion_to_euler_bins_test;
  import qte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1430;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  bit   idling_on = 1'b1;
  bit   hold_req = 1'b0;

  qte_quat_if quat_ch ();
  qte_bins_if bins_ch ();

  quaternion_to_euler_bins i_dut (.clk_i, .rst_ni, .quat_i(quat_ch.sink), .bins_o(bins_ch.source));

  qte_bins_checker i_checker (.clk_i, .rst_ni, .quat_i(quat_ch), .bins_i(bins_ch),
                              .fail_count_o(fail_count), .pending_o(pending));

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    quat_ch.valid  = 1'b0;
    quat_ch.quat_w = '0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    bins_ch.ready  = 1'b0;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_quat(int w, int x, int y, int z);
    int gap;
    gap = idling_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      quat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_w <= IN_W'(w);
    quat_ch.quat_x <= IN_W'(x);
    quat_ch.quat_y <= IN_W'(y);
    quat_ch.quat_z <= IN_W'(z);
    do @(posedge clk_i); while (!quat_ch.ready);
  endtask

  // Mostly unit quaternions of random direction; some raw noise in [-16384, 16384] per component.
  task automatic send_random;
    real c[4], n;
    if ($urandom_range(0, 99) < 15) begin
      send_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
      return;
    end
    n = 0.0;
    foreach (c[k]) begin
      c[k] = real'(int'($urandom_range(0, 65535)) - 32768);
      // Sometimes zero a component to reach axis-aligned and gimbal-lock poses.
      if ($urandom_range(0, 7) == 0) c[k] = 0.0;
      n += c[k] * c[k];
    end
    if (n == 0.0) begin
      send_quat(16384, 0, 0, 0);
      return;
    end
    n = $sqrt(n);
    send_quat($rtoi(16384.0 * c[0] / n), $rtoi(16384.0 * c[1] / n),
              $rtoi(16384.0 * c[2] / n), $rtoi(16384.0 * c[3] / n));
  endtask

  // Result side: random stalls per transaction, one long hold on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = idling_on ? $urandom_range(0, 19) : 0;
      if (hold_req) begin
        bins_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gap > 0) begin
        bins_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      bins_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!bins_ch.valid);
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);        // roll exactly +pi
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);        // yaw exactly +pi
    send_quat(0, 0, 0, -16384);
    send_quat(11585, 0, 11585, 0);    // pitch near +90 degrees
    send_quat(11585, 0, -11585, 0);   // pitch near -90 degrees
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(-16384, 16384, -16384, 16384);
    send_quat(16384, -16384, 16384, -16384);
    send_quat(0, 0, 0, 0);
    send_quat(1, -1, 1, -1);
    send_quat(-1, 1, -1, 1);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 0, -11585);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(16383, 1, -1, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idling_on = !(i >= 500 && i < 700);
      if (i == 800) hold_req = 1'b1;
      if (i == 1100) begin
        // Let the pipeline drain completely before resuming.
        quat_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_random();
    end
    quat_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
